>>> rtl/ppsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsm_pkg: shared types and constants of the pulse period speed meter
// Field widths, register indexes and reset values, and the command that the
// front end passes to the back end through the command queue.
// ----------------------------------------------------------------------------
package ppsm_pkg;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int MINP_W     = 20;
    localparam int PPT_W      = 8;
    localparam int CALIB_W    = 24;
    localparam int CALIB_FRAC = 16;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int FREQ_W     = 28;
    localparam int RPM_W      = 34;
    localparam int SPEED_W    = 40;

    // Microseconds per second, numerator of the frequency division
    localparam longint unsigned US_PER_S = 64'd1000000;

    // Opcodes of an input item
    localparam logic OP_EDGE   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PPT        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB      = 2'd3;

    // Register reset values
    localparam logic [MINP_W-1:0]  MIN_PERIOD_RST = 20'd500;
    localparam logic [TIME_W-1:0]  TIMEOUT_RST    = 32'd2000000;
    localparam logic [PPT_W-1:0]   PPT_RST        = 8'd1;
    localparam logic [CALIB_W-1:0] CALIB_RST      = 24'd65536;

    // Command queue depth
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // What the back end has to do for one update request
    typedef enum logic [1:0] {
        CMD_STOP = 2'd0,
        CMD_HOLD = 2'd1,
        CMD_CALC = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [TIME_W-1:0]   period;
    } cmd_t;

    // Queue status seen by both ends
    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

endpackage

>>> rtl/pulse_period_speed_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_period_speed_meter: pulse period frequency, rpm and speed meter
// Measures the rotor pulse period from timestamped edges with glitch
// rejection and reports frequency, rpm and calibrated speed on request.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries events: opcode 0 is a rising
// edge, opcode 1 an update request, each with its microsecond timestamp.
// An edge transfer only updates the timing state and gives no result. Each
// update transfer gives exactly one result on the output channel (out_valid,
// out_stall) with freq_q8, rpm_q8, speed_q8 and the stopped flag.
// A stopped or held update passes through the command queue and the back end
// states B_IDLE and B_OUT to the output register; a computed update also
// passes B_DIV_F, B_DIV_R, B_MUL and B_SUM and uses the shared
// one-bit-per-cycle divider (DIV_W = max(20 + FRAC_BITS, 34) bits), which
// runs once for the frequency and once for the rpm.
// A two-entry command queue parts the front end from the back end: edges are
// handled while a computation is in progress, and in_stall rises only when
// the queue is full. A result waiting under out_stall holds its fields while
// the back end goes on with the next command.
// Reset clears the edge state, held results and queue, sets the period to
// INIT_PERIOD_US and loads register defaults. The user writes configuration
// (cfg_write, cfg_index, cfg_data) only while idle; the block does not check.
// ----------------------------------------------------------------------------
module pulse_period_speed_meter
    import ppsm_pkg::*;
#(
    parameter int                FRAC_BITS      = 8,
    parameter logic [TIME_W-1:0] INIT_PERIOD_US = 32'd120000
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 opcode,
    input  logic [TIME_W-1:0]    timestamp_us,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [FREQ_W-1:0]    freq_q8,
    output logic [RPM_W-1:0]     rpm_q8,
    output logic [SPEED_W-1:0]   speed_q8,
    output logic                 stopped
);

    logic [MINP_W-1:0]  min_period_reg;
    logic [TIME_W-1:0]  timeout_reg;
    logic [PPT_W-1:0]   ppt_reg;
    logic [CALIB_W-1:0] calib_reg;

    q_status_t q_status;
    logic      q_push;
    logic      q_pop;
    cmd_t      q_push_data;
    cmd_t      q_pop_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_period_reg <= MIN_PERIOD_RST;
            timeout_reg    <= TIMEOUT_RST;
            ppt_reg        <= PPT_RST;
            calib_reg      <= CALIB_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MIN_PERIOD: min_period_reg <= cfg_data[MINP_W-1:0];
                REG_TIMEOUT:    timeout_reg    <= cfg_data[TIME_W-1:0];
                REG_PPT:        ppt_reg        <= cfg_data[PPT_W-1:0];
                REG_CALIB:      calib_reg      <= cfg_data[CALIB_W-1:0];
                default:        ;
            endcase
        end
    end

    ppsm_front #(
        .INIT_PERIOD_US (INIT_PERIOD_US)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .timestamp_us    (timestamp_us),
        .min_period_us   (min_period_reg),
        .stop_timeout_us (timeout_reg),
        .q_status        (q_status),
        .q_push          (q_push),
        .q_data          (q_push_data)
    );

    ppsm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    ppsm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_status           (q_status),
        .q_data             (q_pop_data),
        .q_pop              (q_pop),
        .pulses_per_turn    (ppt_reg),
        .calib_factor_q8_16 (calib_reg),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .freq_q8            (freq_q8),
        .rpm_q8             (rpm_q8),
        .speed_q8           (speed_q8),
        .stopped            (stopped)
    );

`ifndef SYNTHESIS
    // The front end never writes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_status.full)
        else $error("command pushed into a full queue");

    // The back end only takes a command that is there.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_status.valid)
        else $error("command popped from an empty queue");

    // A stopped result carries all zero measurements.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stopped) |-> (freq_q8 == '0 && rpm_q8 == '0 && speed_q8 == '0))
        else $error("stopped result with nonzero fields");

    // Zero frequency implies zero rpm and zero speed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && freq_q8 == '0) |-> (rpm_q8 == '0 && speed_q8 == '0))
        else $error("nonzero rpm or speed at zero frequency");
`endif

endmodule

>>> rtl/ppsm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsm_front: event front end
// Accepts edge and update events, keeps the edge timing state with glitch
// rejection, and turns each update request into a command for the back end.
// ----------------------------------------------------------------------------
module ppsm_front
    import ppsm_pkg::*;
#(
    parameter logic [TIME_W-1:0] INIT_PERIOD_US = 32'd120000
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                opcode,
    input  logic [TIME_W-1:0]   timestamp_us,
    input  logic [MINP_W-1:0]   min_period_us,
    input  logic [TIME_W-1:0]   stop_timeout_us,
    input  q_status_t           q_status,
    output logic                q_push,
    output cmd_t                q_data
);

    logic [TIME_W-1:0] last_edge_reg, last_edge_next;
    logic              edge_seen_reg, edge_seen_next;
    logic [TIME_W-1:0] period_reg, period_next;

    logic              accept;
    logic [TIME_W-1:0] delta;
    logic [TIME_W+1:0] delta_x3;
    logic              too_short;
    logic              below_third;
    logic              timed_out;

    // Events wait while the command queue is full.
    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;

    // Interval since the last accepted edge, modulo 2^32.
    assign delta = timestamp_us - last_edge_reg;

    // delta < floor(period / 3) holds exactly when 3 * delta + 3 <= period.
    assign delta_x3    = {1'b0, delta, 1'b0} + {2'b00, delta} + (TIME_W + 2)'(3);
    assign too_short   = delta < {{(TIME_W - MINP_W){1'b0}}, min_period_us};
    assign below_third = delta_x3 <= {2'b00, period_reg};
    assign timed_out   = delta > stop_timeout_us;

    // Edge timing state update.
    always_comb
    begin
        last_edge_next = last_edge_reg;
        edge_seen_next = edge_seen_reg;
        period_next    = period_reg;
        if (accept && opcode == OP_EDGE)
        begin
            if (!edge_seen_reg)
            begin
                last_edge_next = timestamp_us;
                edge_seen_next = 1'b1;
            end
            else if (!too_short && !below_third)
            begin
                last_edge_next = timestamp_us;
                period_next    = delta;
            end
        end
    end

    // Classification of an update request.
    always_comb
    begin
        q_push        = accept && opcode == OP_UPDATE;
        q_data.period = period_reg;
        if (!edge_seen_reg || timed_out)
        begin
            q_data.kind = CMD_STOP;
        end
        else if (period_reg == '0)
        begin
            q_data.kind = CMD_HOLD;
        end
        else
        begin
            q_data.kind = CMD_CALC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_reg <= '0;
            edge_seen_reg <= 1'b0;
            period_reg    <= INIT_PERIOD_US;
        end
        else
        begin
            last_edge_reg <= last_edge_next;
            edge_seen_reg <= edge_seen_next;
            period_reg    <= period_next;
        end
    end

endmodule

>>> rtl/ppsm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsm_queue: command queue
// Short first-in first-out buffer of commands between front and back end.
// ----------------------------------------------------------------------------
module ppsm_queue
    import ppsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  cmd_t        push_data,
    input  logic        pop,
    output cmd_t        pop_data,
    output q_status_t   status
);

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign status.full  = count_reg == QCNT_W'(QDEPTH);
    assign status.valid = count_reg != '0;
    assign pop_data     = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/ppsm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsm_divider: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses for one cycle
// when the quotient is ready. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module ppsm_divider
    import ppsm_pkg::*;
#(
    parameter int W = 34
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [W-1:0]      dividend,
    input  logic [TIME_W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]      quot_reg, quot_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [TIME_W:0]   rem_shift;
    logic [TIME_W:0]   rem_diff;
    logic              fits;

    assign done     = done_reg;
    assign quotient = quot_reg;

    // One restoring step.
    assign rem_shift = {rem_reg, quot_reg[W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign fits      = rem_shift >= {1'b0, div_reg};

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = CNT_W'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[W-2:0], fits};
            rem_next  = fits ? rem_diff[TIME_W-1:0] : rem_shift[TIME_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

endmodule

>>> rtl/ppsm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsm_back: result back end
// Takes commands from the queue, computes frequency, rpm and speed with a
// shared divider and a split multiplier, and holds the result register.
// ----------------------------------------------------------------------------
module ppsm_back
    import ppsm_pkg::*;
#(
    parameter int FRAC_BITS = 8
)(
    input  logic                clk,
    input  logic                rst_n,
    input  q_status_t           q_status,
    input  cmd_t                q_data,
    output logic                q_pop,
    input  logic [PPT_W-1:0]    pulses_per_turn,
    input  logic [CALIB_W-1:0]  calib_factor_q8_16,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [FREQ_W-1:0]   freq_q8,
    output logic [RPM_W-1:0]    rpm_q8,
    output logic [SPEED_W-1:0]  speed_q8,
    output logic                stopped
);

    localparam int NUM_W  = $clog2(US_PER_S) + FRAC_BITS;
    localparam int DIV_W  = (NUM_W > RPM_W) ? NUM_W : RPM_W;
    localparam int HALF_W = RPM_W / 2;
    localparam int HIGH_W = RPM_W - HALF_W;
    localparam int PROD_W = HIGH_W + CALIB_W;
    localparam int SUM_W  = RPM_W + CALIB_W;
    localparam int SHR_W  = SUM_W - CALIB_FRAC;
    localparam logic [DIV_W-1:0] FREQ_NUM = DIV_W'(US_PER_S << FRAC_BITS);

    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_DIV_F = 6'b000010,
        B_DIV_R = 6'b000100,
        B_MUL   = 6'b001000,
        B_SUM   = 6'b010000,
        B_OUT   = 6'b100000
    } back_state_t;

    back_state_t          state_reg, state_next;
    logic [FREQ_W-1:0]    held_freq_reg, held_freq_next;
    logic [RPM_W-1:0]     held_rpm_reg, held_rpm_next;
    logic [SPEED_W-1:0]   held_speed_reg, held_speed_next;
    logic                 stop_reg, stop_next;
    logic [PROD_W-1:0]    prod_lo_reg, prod_lo_next;
    logic [PROD_W-1:0]    prod_hi_reg, prod_hi_next;
    logic                 out_valid_reg, out_valid_next;
    logic [FREQ_W-1:0]    out_freq_reg;
    logic [RPM_W-1:0]     out_rpm_reg;
    logic [SPEED_W-1:0]   out_speed_reg;
    logic                 out_stop_reg;

    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [TIME_W-1:0]    div_divisor;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quot;

    logic [FREQ_W-1:0]    freq_sat;
    logic [RPM_W-1:0]     freq_x60;
    logic [RPM_W-1:0]     rpm_sat;
    logic [PPT_W-1:0]     ppt_eff;
    logic [SUM_W-1:0]     prod_sum;
    logic [SHR_W-1:0]     speed_full;
    logic [SPEED_W-1:0]   speed_sat;
    logic                 out_load;

    ppsm_divider #(
        .W (DIV_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Saturation and scaling of the divider results.
    assign ppt_eff    = (pulses_per_turn == '0) ? PPT_W'(1) : pulses_per_turn;
    assign freq_sat   = (|div_quot[DIV_W-1:FREQ_W]) ? '1 : div_quot[FREQ_W-1:0];
    assign freq_x60   = {freq_sat, 6'b000000} - {4'b0000, freq_sat, 2'b00};
    assign rpm_sat    = (DIV_W > RPM_W && (div_quot >> RPM_W) != '0) ? '1
                                                                    : div_quot[RPM_W-1:0];
    assign prod_sum   = {prod_hi_reg, {HALF_W{1'b0}}} + SUM_W'(prod_lo_reg);
    assign speed_full = prod_sum[SUM_W-1:CALIB_FRAC];
    assign speed_sat  = (|speed_full[SHR_W-1:SPEED_W]) ? '1 : speed_full[SPEED_W-1:0];

    assign out_load = state_reg == B_OUT && (!out_valid_reg || !out_stall);

    // Sequencer of one command.
    always_comb
    begin
        state_next      = state_reg;
        held_freq_next  = held_freq_reg;
        held_rpm_next   = held_rpm_reg;
        held_speed_next = held_speed_reg;
        stop_next       = stop_reg;
        prod_lo_next    = prod_lo_reg;
        prod_hi_next    = prod_hi_reg;
        q_pop           = 1'b0;
        div_start       = 1'b0;
        div_dividend    = FREQ_NUM;
        div_divisor     = q_data.period;
        case (state_reg)
            B_IDLE:
            begin
                if (q_status.valid)
                begin
                    q_pop     = 1'b1;
                    stop_next = 1'b0;
                    case (q_data.kind)
                        CMD_STOP:
                        begin
                            held_freq_next  = '0;
                            held_rpm_next   = '0;
                            held_speed_next = '0;
                            stop_next       = 1'b1;
                            state_next      = B_OUT;
                        end
                        CMD_CALC:
                        begin
                            div_start  = 1'b1;
                            state_next = B_DIV_F;
                        end
                        default:
                        begin
                            state_next = B_OUT;
                        end
                    endcase
                end
            end
            B_DIV_F:
            begin
                if (div_done)
                begin
                    held_freq_next = freq_sat;
                    div_start      = 1'b1;
                    div_dividend   = DIV_W'(freq_x60);
                    div_divisor    = {{(TIME_W - PPT_W){1'b0}}, ppt_eff};
                    state_next     = B_DIV_R;
                end
            end
            B_DIV_R:
            begin
                if (div_done)
                begin
                    held_rpm_next = rpm_sat;
                    prod_lo_next  = PROD_W'(rpm_sat[HALF_W-1:0]) * PROD_W'(calib_factor_q8_16);
                    state_next    = B_MUL;
                end
            end
            B_MUL:
            begin
                prod_hi_next = PROD_W'(held_rpm_reg[RPM_W-1:HALF_W])
                             * PROD_W'(calib_factor_q8_16);
                state_next   = B_SUM;
            end
            B_SUM:
            begin
                held_speed_next = speed_sat;
                state_next      = B_OUT;
            end
            B_OUT:
            begin
                if (out_load)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Output register valid.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            held_freq_reg  <= '0;
            held_rpm_reg   <= '0;
            held_speed_reg <= '0;
            stop_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_freq_reg  <= held_freq_next;
            held_rpm_reg   <= held_rpm_next;
            held_speed_reg <= held_speed_next;
            stop_reg       <= stop_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Partial products and result payload, no reset needed.
    always_ff @(posedge clk)
    begin
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
        if (out_load)
        begin
            out_freq_reg  <= held_freq_reg;
            out_rpm_reg   <= held_rpm_reg;
            out_speed_reg <= held_speed_reg;
            out_stop_reg  <= stop_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign freq_q8   = out_freq_reg;
    assign rpm_q8    = out_rpm_reg;
    assign speed_q8  = out_speed_reg;
    assign stopped   = out_stop_reg;

endmodule
